// ===== sv/pprau_pkg.sv =====
package pprau_pkg;

   localparam int PIXEL_MEM_DEPTH   = 524288;
   localparam int MEM_AW            = $clog2(PIXEL_MEM_DEPTH);
   localparam int PIXELS_PER_ACCESS = 16;
   localparam int PIX_IDX_W         = $clog2(PIXELS_PER_ACCESS);
   localparam int ADDR_W            = 19;
   localparam int CNT_W             = 13;
   localparam int CSR_IDX_W         = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROP_CONTROL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_PROTECT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_AMOUNTS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_ONE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_TWO   = 3'd6;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LOAD  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // classified transaction handed from front to back
   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] base;
      logic [15:0]       data;
      logic [2:0]        plane;
   } job_type;

   typedef struct packed {
      logic [15:0] rop_control;
      logic [7:0]  plane_protect;
      logic [15:0] pixel_enable;
      logic [11:0] block_length;
      logic [15:0] shift_amounts;
      logic [7:0]  palette_one;
      logic [7:0]  palette_two;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_WR_ADDR,
      ST_WR_DATA,
      ST_WR_STORE,
      ST_DONE
   } state_type;

   // enable bit for pixel i: bit order reversed within each byte
   function automatic logic [3:0] enable_pos(input logic [PIX_IDX_W-1:0] i);
      enable_pos = {i[3], ~i[2:0]};
   endfunction

   // ternary raster op, one minterm per code bit (S*4 + D*2 + P)
   function automatic logic [7:0] rop3(input logic [7:0] code, input logic [7:0] s,
                                       input logic [7:0] d, input logic [7:0] p1,
                                       input logic [7:0] p2);
      logic [7:0] r;
      r = 8'd0;
      if (code[7]) r |= s & d & p1;
      if (code[6]) r |= s & d & ~p1;
      if (code[5]) r |= s & ~d & p1;
      if (code[4]) r |= s & ~d & ~p1;
      if (code[3]) r |= ~s & d & p2;
      if (code[2]) r |= ~s & d & ~p2;
      if (code[1]) r |= ~s & ~d & p2;
      if (code[0]) r |= ~s & ~d & ~p2;
      rop3 = r;
   endfunction

endpackage

// ===== sv/pprau_front.sv =====
module pprau_front import pprau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [16:0] req_bus_offset,
   input  logic [15:0] req_write_data,
   input  logic [2:0]  req_pattern_plane,
   input  csr_type     csr,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_take
);

   // two-entry queue of classified transactions
   job_type    q_ff [2];
   job_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   job_type    nj;
   logic [4:0] sh;

   always_comb begin
      sh = (cmd_type'(req_cmd) == CMD_WRITE) ? csr.shift_amounts[12:8]
                                              : csr.shift_amounts[4:0];
      nj.cmd   = cmd_type'(req_cmd);
      nj.base  = {req_bus_offset[15:0], 3'b000} + {14'd0, sh};
      nj.data  = req_write_data;
      nj.plane = req_pattern_plane;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (job_take && job_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push_ok) begin
         q_in[cnt_in[0]] = nj;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/pprau_back.sv =====
module pprau_back import pprau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_take,
   input  csr_type          csr,
   output logic             res_valid,
   output logic [15:0]      res_read_data,
   output logic [CNT_W-1:0] res_remaining,
   input  logic             res_take
);

   logic [7:0]           mem [PIXEL_MEM_DEPTH];
   logic [7:0]           rdata_ff;
   logic                 mem_we;
   logic [MEM_AW-1:0]    mem_addr;
   logic [7:0]           mem_wdata;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [PIX_IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]          match_ff, match_in;
   logic [7:0]           latch_ff [PIXELS_PER_ACCESS];
   logic [15:0]          pat_ff [8];
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 res_valid_ff, res_valid_in;
   logic [15:0]          res_rd_ff, res_rd_in;
   logic [CNT_W-1:0]     res_rem_ff, res_rem_in;

   logic [ADDR_W-1:0]    paddr;
   logic                 last_pix;
   logic [7:0]           pcol, p1, p2, src, wout, prot;
   logic                 en;
   logic [3:0]           epos;
   logic [CNT_W-1:0]     rem_dec;

   assign prot = csr.plane_protect;
   assign paddr = csr.rop_control[9] ? job_ff.base - ADDR_W'(idx_ff)
                                     : job_ff.base + ADDR_W'(idx_ff);
   assign mem_addr = MEM_AW'(paddr);
   assign last_pix = (idx_ff == PIX_IDX_W'(PIXELS_PER_ACCESS - 1));
   assign epos = enable_pos(idx_ff);
   assign en = csr.pixel_enable[epos];
   assign rem_dec = remain_ff - CNT_W'(1);

   always_comb begin
      for (int j = 0; j < 8; j++) pcol[j] = pat_ff[j][idx_ff];
      case (csr.rop_control[11:10])
         2'd0: begin p1 = pcol; p2 = pcol; end
         2'd1: begin p1 = csr.palette_two; p2 = csr.palette_two; end
         2'd2: begin p1 = csr.palette_one; p2 = csr.palette_one; end
         default: begin p1 = csr.palette_one; p2 = csr.palette_two; end
      endcase
      src = csr.rop_control[8] ? {8{job_ff.data[epos]}} : latch_ff[idx_ff];
      if (csr.rop_control[12])
         wout = (rdata_ff & prot) | (rop3(csr.rop_control[7:0], src, rdata_ff, p1, p2) & ~prot);
      else
         wout = (rdata_ff & prot) | (src & ~prot);
   end

   assign mem_we    = (state_ff == ST_WR_STORE) && en;
   assign mem_wdata = wout;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rdata_ff <= mem[mem_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               case (job.cmd)
                  CMD_READ: state_in = csr.rop_control[8] ? ST_DONE : ST_RD_ADDR;
                  CMD_WRITE: state_in = ST_WR_ADDR;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: state_in = last_pix ? ST_DONE : ST_RD_ADDR;
         ST_WR_ADDR: state_in = ST_WR_DATA;
         ST_WR_DATA: state_in = ST_WR_STORE;
         ST_WR_STORE: state_in = (last_pix || rem_dec == '0) ? ST_DONE : ST_WR_ADDR;
         ST_DONE: if (!res_valid_ff || res_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      job_take     = (state_ff == ST_IDLE) && job_valid;
      job_in       = job_take ? job : job_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      remain_in    = remain_ff;
      res_valid_in = res_valid_ff && !res_take;
      res_rd_in    = res_rd_ff;
      res_rem_in   = res_rem_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in   = '0;
            match_in = '0;
            if (job_take && job.cmd == CMD_WRITE && remain_ff == '0)
               remain_in = {1'b0, csr.block_length} + CNT_W'(1);
         end
         ST_RD_DATA: begin
            match_in[idx_ff] = |((rdata_ff ^ csr.palette_one) & ~prot);
            idx_in = idx_ff + PIX_IDX_W'(1);
         end
         ST_WR_STORE: begin
            remain_in = rem_dec;
            idx_in    = idx_ff + PIX_IDX_W'(1);
         end
         ST_DONE: begin
            if (!res_valid_ff || res_take) begin
               res_valid_in = 1'b1;
               res_rd_in    = (job_ff.cmd == CMD_READ) ? match_ff : 16'd0;
               res_rem_in   = remain_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      res_rd_ff <= res_rd_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         res_valid_ff <= 1'b0;
         res_rem_ff   <= '0;
         for (int i = 0; i < PIXELS_PER_ACCESS; i++) latch_ff[i] <= 8'd0;
         for (int j = 0; j < 8; j++) pat_ff[j] <= 16'd0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         res_valid_ff <= res_valid_in;
         res_rem_ff   <= res_rem_in;
         if (state_ff == ST_RD_DATA) begin
            latch_ff[idx_ff] <= rdata_ff;
            if (csr.rop_control[13])
               for (int j = 0; j < 8; j++) pat_ff[j][idx_ff] <= rdata_ff[j];
         end
         if (job_take && job.cmd == CMD_LOAD) pat_ff[job.plane] <= job.data;
      end
   end

   assign res_valid     = res_valid_ff;
   assign res_read_data = res_rd_ff;
   assign res_remaining = res_rem_ff;

endmodule

// ===== sv/planar_pixel_rop_access_unit.sv =====
// One memory port. A read passes RD_ADDR, RD_DATA per pixel; a write WR_ADDR, WR_DATA,
//   WR_STORE per pixel up to the last or until the count runs out; pattern load, unused
//   command or a read with rop_control[8] set goes to DONE directly. The back end takes
//   one job at a time; a 2-entry queue buffers the front, an unpopped response stalls.
// Reset: synchronous active high; clears state, CSRs, latches, pattern planes, counter
//   and queue. Pixel memory is not cleared.
module planar_pixel_rop_access_unit import pprau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             full,
   input  logic [1:0]       req_cmd,
   input  logic [16:0]      req_bus_offset,
   input  logic [15:0]      req_write_data,
   input  logic [2:0]       req_pattern_plane,
   output logic             empty,
   input  logic             rsp_pop,
   output logic [15:0]      rsp_read_data,
   output logic [CNT_W-1:0] rsp_pixels_remaining,
   input  logic             csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]      csr_wdata
);

   csr_type          csr_ff;
   logic             job_valid, job_take, res_valid;
   job_type          job;
   logic [15:0]      res_rd;
   logic [CNT_W-1:0] res_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROP_CONTROL:   csr_ff.rop_control   <= csr_wdata;
            CSR_PLANE_PROTECT: csr_ff.plane_protect <= csr_wdata[7:0];
            CSR_PIXEL_ENABLE:  csr_ff.pixel_enable  <= csr_wdata;
            CSR_BLOCK_LENGTH:  csr_ff.block_length  <= csr_wdata[11:0];
            CSR_SHIFT_AMOUNTS: csr_ff.shift_amounts <= csr_wdata;
            CSR_PALETTE_ONE:   csr_ff.palette_one   <= csr_wdata[7:0];
            CSR_PALETTE_TWO:   csr_ff.palette_two   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   pprau_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(full),
      .req_cmd(req_cmd), .req_bus_offset(req_bus_offset),
      .req_write_data(req_write_data), .req_pattern_plane(req_pattern_plane),
      .csr(csr_ff), .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   pprau_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_take(job_take), .csr(csr_ff), .res_valid(res_valid),
      .res_read_data(res_rd), .res_remaining(res_rem), .res_take(rsp_pop)
   );

   assign empty                = !res_valid;
   assign rsp_read_data        = res_rd;
   assign rsp_pixels_remaining = res_rem;

`ifndef SYNTHESIS
   a_take_needs_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("job taken from empty queue");
   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      res_rem <= CNT_W'(4096)) else $error("remain count out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_pop) |=> (!empty && $stable(rsp_read_data)
                                && $stable(rsp_pixels_remaining)))
      else $error("response changed while waiting");
`endif

endmodule
